>>> hw/rtl/dda_pkg.sv
// Shared constants, codes and controller/datapath types for the DDA line rasterizer.
`timescale 1ns / 1ps

package dda_pkg;

  localparam int COORD_BITS   = 11;
  localparam int FRAC_BITS    = 16;
  localparam int DIM_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;
  localparam int POS_OUT_BITS = 12;
  localparam int OFF_BITS     = 20;
  localparam int COLOR_BITS   = 8;

  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int DEN_BITS     = COORD_BITS + 1;
  localparam int NUM_BITS     = COORD_BITS + FRAC_BITS + 1;
  localparam int ACC_BITS     = NUM_BITS;
  localparam int QUO_BITS     = FRAC_BITS + 1;
  localparam int SLOPE_BITS   = FRAC_BITS + 2;
  localparam int MINOR_BITS   = COORD_BITS + 1;
  localparam int MAP_BITS     = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
  localparam int PROD_BITS    = 2 * DIM_BITS;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(600);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(600);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_finish;
    logic pix_round;
    logic pix_map;
    logic pix_mul;
    logic out_load;
  } dda_ctl_t;

  typedef struct packed {
    logic line_active;
    logic out_free;
  } dda_stat_t;

endpackage

>>> hw/rtl/dda_if.sv
// Valid/ready channel interfaces for line commands, pixels and configuration writes.
`timescale 1ns / 1ps

interface dda_in_if import dda_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0]        red;
  logic [COLOR_BITS-1:0]        green;
  logic [COLOR_BITS-1:0]        blue;

  modport source (output valid, command, start_x, start_y, end_x, end_y, red, green, blue,
                  input ready);
  modport sink (input valid, command, start_x, start_y, end_x, end_y, red, green, blue,
                output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [POS_OUT_BITS-1:0] column;
  logic signed [POS_OUT_BITS-1:0] row;
  logic [OFF_BITS-1:0]            pixel_offset;
  logic                           in_bounds;
  logic [COLOR_BITS-1:0]          pixel_red;
  logic [COLOR_BITS-1:0]          pixel_green;
  logic [COLOR_BITS-1:0]          pixel_blue;
  logic                           last_pixel;

  modport source (output valid, column, row, pixel_offset, in_bounds, pixel_red, pixel_green,
                  pixel_blue, last_pixel, input ready);
  modport sink (input valid, column, row, pixel_offset, in_bounds, pixel_red, pixel_green,
                pixel_blue, last_pixel, output ready);
endinterface

interface dda_cfg_if import dda_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DIM_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/dda_ctrl.sv
// Controller state machine sequencing line setup, slope division and pixel steps.
`timescale 1ns / 1ps

module dda_ctrl import dda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_ready,
  input  dda_stat_t stat,
  output dda_ctl_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FIN,
    S_ROUND,
    S_MAP,
    S_MUL,
    S_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    accept;
  logic                    is_step;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_step  = (in_command == CMD_STEP);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !is_step) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (accept && stat.line_active) begin
          state_nxt = S_ROUND;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(NUM_BITS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ctl.div_finish = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_ROUND: begin
        ctl.pix_round = 1'b1;
        state_nxt     = S_MAP;
      end
      S_MAP: begin
        ctl.pix_map = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        ctl.pix_mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/dda_dp.sv
// Datapath: canvas registers, line setup, slope divider, DDA walk, mapping and result register.
`timescale 1ns / 1ps

module dda_dp import dda_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dda_ctl_t                     ctl,
  output dda_stat_t                    stat,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0]        red,
  input  logic [COLOR_BITS-1:0]        green,
  input  logic [COLOR_BITS-1:0]        blue,
  dda_out_if.source                    out_beat,
  dda_cfg_if.sink                      cfg_beat
);

  localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

  // canvas and line state
  logic [DIM_BITS-1:0]          width_r, height_r;
  logic                         active_r;
  logic                         xmaj_r;
  logic signed [COORD_BITS-1:0] pos_r, end_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic signed [SLOPE_BITS-1:0] slope_r;
  logic [COLOR_BITS-1:0]        red_r, green_r, blue_r;
  logic                         zero_r, neg_r;

  // divider
  logic [DEN_BITS-1:0]          den_r;
  logic [NUM_BITS-1:0]          num_r;
  logic [DEN_BITS-1:0]          rem_r;
  logic [QUO_BITS-1:0]          quo_r;

  // pixel pipeline
  logic signed [MINOR_BITS-1:0] x_r, y_r;
  logic                         last_r;
  logic signed [MAP_BITS-1:0]   col_r, row_r;
  logic                         inb_r;
  logic [OFF_BITS-1:0]          off_r;

  // result register
  logic                           out_valid_r;
  logic signed [POS_OUT_BITS-1:0] out_col_r, out_row_r;
  logic [OFF_BITS-1:0]            out_off_r;
  logic                           out_inb_r, out_last_r;
  logic [COLOR_BITS-1:0]          out_red_r, out_green_r, out_blue_r;

  // line setup
  logic signed [DIFF_BITS-1:0]  dx, dy;
  logic [DIFF_BITS-1:0]         ax, ay, dmaj, amin;
  logic                         xm, swap, mneg;
  logic signed [COORD_BITS-1:0] i0, i1, d0;
  logic [NUM_BITS-1:0]          num_init;

  assign dx   = DIFF_BITS'(end_x) - DIFF_BITS'(start_x);
  assign dy   = DIFF_BITS'(end_y) - DIFF_BITS'(start_y);
  assign ax   = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
  assign ay   = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
  assign xm   = (ax > ay);
  assign dmaj = xm ? ax : ay;
  assign amin = xm ? ay : ax;
  assign swap = xm ? dx[DIFF_BITS-1] : dy[DIFF_BITS-1];
  assign mneg = (xm ? dy[DIFF_BITS-1] : dx[DIFF_BITS-1]) ^ swap;

  always_comb begin
    if (xm) begin
      i0 = swap ? end_x : start_x;
      i1 = swap ? start_x : end_x;
      d0 = swap ? end_y : start_y;
    end else begin
      i0 = swap ? end_y : start_y;
      i1 = swap ? start_y : end_y;
      d0 = swap ? end_x : start_x;
    end
  end

  assign num_init = (NUM_BITS'(amin[COORD_BITS-1:0]) << (FRAC_BITS + 1))
                  + NUM_BITS'(dmaj[COORD_BITS-1:0]);

  // restoring divider, one quotient bit per cycle
  logic [DEN_BITS:0]   trial;
  logic                qbit;
  logic [DEN_BITS-1:0] rem_nxt;

  assign trial = {rem_r, num_r[NUM_BITS-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_comb begin
    if (qbit) begin
      rem_nxt = DEN_BITS'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DEN_BITS-1:0];
    end
  end

  logic signed [SLOPE_BITS-1:0] quo_s;
  assign quo_s = signed'(SLOPE_BITS'(quo_r));

  // rounding of the minor accumulator, half away from zero
  logic [ACC_BITS-1:0]          acc_mag, acc_rnd;
  logic [MINOR_BITS-1:0]        rq;
  logic signed [MINOR_BITS-1:0] minor;
  logic                         last_now;

  assign acc_mag  = acc_r[ACC_BITS-1] ? ACC_BITS'(-acc_r) : ACC_BITS'(acc_r);
  assign acc_rnd  = acc_mag + HALF;
  assign rq       = acc_rnd[ACC_BITS-1:FRAC_BITS];
  assign minor    = acc_r[ACC_BITS-1] ? -signed'(rq) : signed'(rq);
  assign last_now = (pos_r >= end_r);

  // canvas mapping
  logic signed [MAP_BITS-1:0] half_w, half_h, w_s, h_s, col, row;
  logic                       inb;

  assign half_w = signed'(MAP_BITS'(width_r >> 1));
  assign half_h = signed'(MAP_BITS'(height_r >> 1));
  assign w_s    = signed'(MAP_BITS'(width_r));
  assign h_s    = signed'(MAP_BITS'(height_r));
  assign col    = half_w + MAP_BITS'(x_r);
  assign row    = half_h - MAP_BITS'(y_r) - MAP_BITS'(1);
  assign inb    = (col >= 0) && (col < w_s) && (row >= 0) && (row < h_s);

  // frame-buffer offset
  logic [PROD_BITS-1:0] prod;
  logic [OFF_BITS-1:0]  off;

  assign prod = PROD_BITS'(row_r[DIM_BITS-1:0]) * PROD_BITS'(width_r);
  assign off  = prod[OFF_BITS-1:0] + OFF_BITS'(col_r[DIM_BITS-1:0]);

  assign stat.line_active = active_r;
  assign stat.out_free    = !out_valid_r || out_beat.ready;
  assign cfg_beat.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_beat.valid) begin
        case (cfg_reg_t'(cfg_beat.index))
          CFG_WIDTH:  width_r  <= cfg_beat.data;
          CFG_HEIGHT: height_r <= cfg_beat.data;
          default: ;
        endcase
      end
      if (ctl.load) begin
        active_r <= 1'b1;
      end else if (ctl.pix_round && last_now) begin
        active_r <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      xmaj_r  <= xm;
      pos_r   <= i0;
      end_r   <= i1;
      acc_r   <= ACC_BITS'(d0) <<< FRAC_BITS;
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      zero_r  <= (dmaj == '0);
      neg_r   <= mneg;
      den_r   <= {dmaj[COORD_BITS-1:0], 1'b0};
      num_r   <= num_init;
      rem_r   <= '0;
      quo_r   <= '0;
    end
    if (ctl.div_step) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[NUM_BITS-2:0], 1'b0};
      quo_r <= {quo_r[QUO_BITS-2:0], qbit};
    end
    if (ctl.div_finish) begin
      slope_r <= zero_r ? '0 : (neg_r ? -quo_s : quo_s);
    end
    if (ctl.pix_round) begin
      x_r    <= xmaj_r ? MINOR_BITS'(pos_r) : minor;
      y_r    <= xmaj_r ? minor : MINOR_BITS'(pos_r);
      last_r <= last_now;
      if (!last_now) begin
        pos_r <= pos_r + COORD_BITS'(1);
        acc_r <= acc_r + ACC_BITS'(slope_r);
      end
    end
    if (ctl.pix_map) begin
      col_r <= col;
      row_r <= row;
      inb_r <= inb;
    end
    if (ctl.pix_mul) begin
      off_r <= inb_r ? off : '0;
    end
    if (ctl.out_load) begin
      out_col_r   <= col_r[POS_OUT_BITS-1:0];
      out_row_r   <= row_r[POS_OUT_BITS-1:0];
      out_off_r   <= off_r;
      out_inb_r   <= inb_r;
      out_last_r  <= last_r;
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.column       = out_col_r;
  assign out_beat.row          = out_row_r;
  assign out_beat.pixel_offset = out_off_r;
  assign out_beat.in_bounds    = out_inb_r;
  assign out_beat.pixel_red    = out_red_r;
  assign out_beat.pixel_green  = out_green_r;
  assign out_beat.pixel_blue   = out_blue_r;
  assign out_beat.last_pixel   = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_beat.ready))
    else $error("result register overwritten while a beat was pending");

  a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pix_round |-> active_r)
    else $error("pixel step issued with no active line");

  a_active_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(active_r) |-> $past(ctl.load))
    else $error("line became active without a load");

endmodule

>>> hw/rtl/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: controller, datapath and channel ports.
`timescale 1ns / 1ps

// A load beat (command 0) takes two endpoints in centered coordinates and a color, picks the
// major axis and computes the slope with a restoring divider that produces one bit per cycle;
// the block takes no new command until that slope is stored. A step beat (command 1) emits
// one pixel through round, map and multiply stages and a result register, which is loaded
// only once the sink has taken the previous beat; a step with no active line is dropped.
// The result register lets the block take the next command while a pixel beat is still
// pending.
// Configuration writes of canvas width and height are accepted every cycle.
module dda_line_rasterizer import dda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dda_in_if.sink     in_beat,
  dda_out_if.source  out_beat,
  dda_cfg_if.sink    cfg_beat
);

  dda_ctl_t  ctl;
  dda_stat_t stat;
  logic      in_ready;

  assign in_beat.ready = in_ready;

  dda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_beat.valid),
    .in_command (in_beat.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  dda_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .stat     (stat),
    .start_x  (in_beat.start_x),
    .start_y  (in_beat.start_y),
    .end_x    (in_beat.end_x),
    .end_y    (in_beat.end_y),
    .red      (in_beat.red),
    .green    (in_beat.green),
    .blue     (in_beat.blue),
    .out_beat (out_beat),
    .cfg_beat (cfg_beat)
  );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the DDA line rasterizer: directed and random line walks, checked per pixel.
`timescale 1ns / 1ps

module testbench;
  import dda_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = NUM_BITS + 12;
  localparam int BREAK_PCT     = 18;
  localparam int COORD_MIN     = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;

  typedef struct packed {
    cmd_t                         command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        red;
    logic [COLOR_BITS-1:0]        green;
    logic [COLOR_BITS-1:0]        blue;
  } line_cmd_t;

  typedef struct packed {
    logic signed [POS_OUT_BITS-1:0] column;
    logic signed [POS_OUT_BITS-1:0] row;
    logic [OFF_BITS-1:0]            pixel_offset;
    logic                           in_bounds;
    logic [COLOR_BITS-1:0]          red;
    logic [COLOR_BITS-1:0]          green;
    logic [COLOR_BITS-1:0]          blue;
    logic                           last_pixel;
  } pixel_t;

  typedef struct {
    bit                    active;
    bit                    x_major;
    longint                position;
    longint                last_major;
    longint                acc;
    longint                slope;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } walk_state_t;

  logic clk;
  logic rst_n;

  dda_in_if  in_if ();
  dda_out_if out_if ();
  dda_cfg_if cfg_if ();

  dda_line_rasterizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_if),
    .out_beat (out_if),
    .cfg_beat (cfg_if)
  );

  walk_state_t walk;
  int          canvas_w;
  int          canvas_h;
  pixel_t      pixel_queue[$];
  bit          calm;
  int          errors;
  int          cycle_count;
  int          loads_taken;
  int          pixels_checked;
  int          pixels_on_canvas;
  int          canvas_settings;
  int          walk_items;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= BREAK_PCT);
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint round_minor(input longint acc);
    longint half;
    half = longint'(1) << (FRAC_BITS - 1);
    if (acc >= 0) return (acc + half) >>> FRAC_BITS;
    return -((-acc + half) >>> FRAC_BITS);
  endfunction

  function automatic bit rasterize_beat(input line_cmd_t c, output pixel_t px);
    longint x0, y0, x1, y1, a0, b0, a1, b1, dmaj, dmin, mag;
    longint minor, pos_x, pos_y, col, row, w, h;
    bit     inb;
    px = '0;
    if (c.command == CMD_LOAD) begin
      x0 = $signed(c.start_x);
      y0 = $signed(c.start_y);
      x1 = $signed(c.end_x);
      y1 = $signed(c.end_y);
      walk.x_major = magnitude(x1 - x0) > magnitude(y1 - y0);
      if (walk.x_major) begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end else begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end
      if (a1 < a0) begin
        {a0, a1} = {a1, a0};
        {b0, b1} = {b1, b0};
      end
      dmaj = a1 - a0;
      dmin = b1 - b0;
      if (dmaj == 0) begin
        walk.slope = 0;
      end else begin
        mag = (2 * (magnitude(dmin) << FRAC_BITS) + dmaj) / (2 * dmaj);
        walk.slope = (dmin < 0) ? -mag : mag;
      end
      walk.position   = a0;
      walk.last_major = a1;
      walk.acc        = b0 * (longint'(1) << FRAC_BITS);
      walk.red        = c.red;
      walk.green      = c.green;
      walk.blue       = c.blue;
      walk.active     = 1'b1;
      return 1'b0;
    end
    if (!walk.active) return 1'b0;
    minor = round_minor(walk.acc);
    pos_x = walk.x_major ? walk.position : minor;
    pos_y = walk.x_major ? minor : walk.position;
    w = canvas_w;
    h = canvas_h;
    col = w / 2 + pos_x;
    row = h / 2 - pos_y - 1;
    inb = (col >= 0) && (col < w) && (row >= 0) && (row < h);
    px.column       = col[POS_OUT_BITS-1:0];
    px.row          = row[POS_OUT_BITS-1:0];
    px.pixel_offset = inb ? OFF_BITS'(row * w + col) : '0;
    px.in_bounds    = inb;
    px.red          = walk.red;
    px.green        = walk.green;
    px.blue         = walk.blue;
    px.last_pixel   = walk.position >= walk.last_major;
    if (px.last_pixel) begin
      walk.active = 1'b0;
    end else begin
      walk.position += 1;
      walk.acc += walk.slope;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    line_cmd_t beat;
    pixel_t    px;
    pixel_t    want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_t'(cfg_if.index))
          CFG_WIDTH:  canvas_w = cfg_if.data;
          CFG_HEIGHT: canvas_h = cfg_if.data;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        beat.command = cmd_t'(in_if.command);
        beat.start_x = in_if.start_x;
        beat.start_y = in_if.start_y;
        beat.end_x   = in_if.end_x;
        beat.end_y   = in_if.end_y;
        beat.red     = in_if.red;
        beat.green   = in_if.green;
        beat.blue    = in_if.blue;
        if (beat.command == CMD_LOAD) loads_taken++;
        if (rasterize_beat(beat, px)) pixel_queue = {pixel_queue, px};
      end
      if (out_if.valid && out_if.ready) begin
        if (pixel_queue.size() == 0) begin
          $error("pixel beat with no pixel pending: column %0d row %0d",
                 out_if.column, out_if.row);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          check_field("column", $signed(want.column), $signed(out_if.column));
          check_field("row", $signed(want.row), $signed(out_if.row));
          check_field("pixel_offset", want.pixel_offset, out_if.pixel_offset);
          check_field("in_bounds", want.in_bounds, out_if.in_bounds);
          check_field("pixel_red", want.red, out_if.pixel_red);
          check_field("pixel_green", want.green, out_if.pixel_green);
          check_field("pixel_blue", want.blue, out_if.pixel_blue);
          check_field("last_pixel", want.last_pixel, out_if.last_pixel);
          pixels_checked++;
          if (want.in_bounds) pixels_on_canvas++;
        end
      end
    end else begin
      walk     = '{default: '0};
      canvas_w = WIDTH_RESET;
      canvas_h = HEIGHT_RESET;
    end
  end

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int rand_coord();
    logic signed [COORD_BITS-1:0] v;
    v = COORD_BITS'($urandom);
    return v;
  endfunction

  function automatic line_cmd_t load_cmd(input int sx, input int sy, input int ex, input int ey);
    line_cmd_t c;
    c.command = CMD_LOAD;
    c.start_x = COORD_BITS'(clamp_coord(sx));
    c.start_y = COORD_BITS'(clamp_coord(sy));
    c.end_x   = COORD_BITS'(clamp_coord(ex));
    c.end_y   = COORD_BITS'(clamp_coord(ey));
    c.red     = COLOR_BITS'($urandom);
    c.green   = COLOR_BITS'($urandom);
    c.blue    = COLOR_BITS'($urandom);
    return c;
  endfunction

  function automatic line_cmd_t step_cmd();
    line_cmd_t c;
    c = load_cmd(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    c.command = CMD_STEP;
    return c;
  endfunction

  function automatic int line_length(input line_cmd_t c);
    int dx, dy, sx, sy, ex, ey;
    sx = $signed(c.start_x);
    sy = $signed(c.start_y);
    ex = $signed(c.end_x);
    ey = $signed(c.end_y);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  task automatic send_beat(input line_cmd_t c);
    while (!calm && ($urandom_range(99) < BREAK_PCT)) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.command <= c.command;
    in_if.start_x <= c.start_x;
    in_if.start_y <= c.start_y;
    in_if.end_x   <= c.end_x;
    in_if.end_y   <= c.end_y;
    in_if.red     <= c.red;
    in_if.green   <= c.green;
    in_if.blue    <= c.blue;
    in_if.valid   <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // cut < 0 or cut at or beyond the line length walks the whole line; otherwise stop after cut steps
  task automatic walk_line(input line_cmd_t c, input int cut);
    int steps;
    steps = line_length(c);
    if (cut >= 0 && cut < steps) steps = cut;
    send_beat(c);
    repeat (steps) send_beat(step_cmd());
    walk_items += 1 + steps;
  endtask

  task automatic drain_pixels(input bit settle);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pixel_queue.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_canvas(input int w, input int h);
    drain_pixels(1'b1);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_WIDTH;
    cfg_if.data  <= DIM_BITS'(w);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CFG_HEIGHT;
    cfg_if.data  <= DIM_BITS'(h);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    canvas_settings++;
  endtask

  task automatic test_directed_lines();
    line_cmd_t c;
    send_beat(step_cmd());
    c = load_cmd(0, 0, 0, 0);
    c.red   = 8'hFF;
    c.green = 8'hFF;
    c.blue  = 8'hFF;
    walk_line(c, -1);
    send_beat(step_cmd());
    c = load_cmd(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    c.red   = 8'h00;
    c.green = 8'h00;
    c.blue  = 8'h00;
    walk_line(c, 3);
    walk_line(load_cmd(COORD_MAX, COORD_MAX, COORD_MIN, -1000), 2);
    walk_line(load_cmd(0, 0, 4, -2), -1);
    walk_line(load_cmd(2, 2, 2, -1), -1);
    walk_line(load_cmd(0, 0, 1, 3), -1);
  endtask

  task automatic test_canvas_extremes();
    int dims[6][2] = '{'{1, 1}, '{1024, 1024}, '{0, 0}, '{2047, 2047}, '{1024, 1}, '{1, 601}};
    int w, h;
    foreach (dims[i]) begin
      w = dims[i][0];
      h = dims[i][1];
      write_canvas(w, h);
      walk_line(load_cmd(-w / 2 - 2, 1, -w / 2 + 1, 1), -1);
      walk_line(load_cmd(w - 1 - w / 2 - 1, -1, w - 1 - w / 2 + 2, -1), -1);
      walk_line(load_cmd(0, h / 2 - 2, 1, h / 2 + 1), -1);
      walk_line(load_cmd(-1, h / 2 - h - 1, 0, h / 2 - h + 2), -1);
      walk_line(load_cmd(-1, 1, 1, -1), -1);
      if (w == 2047) walk_line(load_cmd(COORD_MIN, COORD_MIN, COORD_MAX, -1000), 64);
    end
  endtask

  task automatic test_random_lines(input int total);
    int per_phase, w, h, kind, sx, sy, span, pick;
    int odd_dims[4] = '{0, 1, 1024, 2047};
    per_phase = total / 6;
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        w = WIDTH_RESET;
        h = HEIGHT_RESET;
      end else if ($urandom_range(4) == 0) begin
        w = odd_dims[$urandom_range(3)];
        h = odd_dims[$urandom_range(3)];
      end else begin
        w = $urandom_range(1, 1024);
        h = $urandom_range(1, 1024);
      end
      write_canvas(w, h);
      calm = (p == 2);
      walk_items = 0;
      while (walk_items < per_phase) begin
        if ($urandom_range(1)) begin
          sx = $urandom_range(w) - w / 2;
          sy = $urandom_range(h) - h / 2;
        end else begin
          sx = rand_coord();
          sy = rand_coord();
        end
        kind = $urandom_range(99);
        if (kind < 75) begin
          span = (kind < 60) ? 12 : 120;
          walk_line(load_cmd(sx, sy, sx + $urandom_range(2 * span) - span,
                             sy + $urandom_range(2 * span) - span), -1);
          if ($urandom_range(3) == 0) send_beat(step_cmd());
        end else if (kind < 90) begin
          walk_line(load_cmd(sx, sy, rand_coord(), rand_coord()), $urandom_range(20));
        end else begin
          pick = $urandom_range(1, 3);
          repeat (pick) send_beat(step_cmd());
        end
        if ($urandom_range(149) == 0) drain_pixels(1'b0);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.end_x = '0;
    in_if.end_y = '0;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_WIDTH;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_canvas_extremes();
    test_random_lines(800);
    drain_pixels(1'b1);

    $display("Covered %0d line loads and %0d checked pixels (%0d on canvas)",
             loads_taken, pixels_checked, pixels_on_canvas);
    $display("across %0d canvas settings, including zero and oversized dimensions",
             canvas_settings);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
